// ----- rtl/rfd_pkg.sv -----
package rfd_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hBB;
  localparam logic [15:0] TIMEOUT_RESET = 16'd20;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD     = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_t;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_TYPE    = 7'b0000010,
    PH_CMD     = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    ev_t         event_res;
    logic [7:0]  frame_type;
    logic [7:0]  frame_command;
    logic [15:0] payload_length;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
  } res_t;

  typedef struct packed {
    logic room;
  } out_ctl_t;

endpackage

// ----- rtl/rfd_if.sv -----
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  modport source (output valid, opcode, rx_byte, input ready);
  modport sink (input valid, opcode, rx_byte, output ready);
endinterface

interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  frame_type;
  logic [7:0]  frame_command;
  logic [15:0] payload_length;
  logic [15:0] payload_index;
  logic [7:0]  payload_byte;
  modport source (output valid, event_res, frame_type, frame_command, payload_length,
                  payload_index, payload_byte, input ready);
  modport sink (input valid, event_res, frame_type, frame_command, payload_length,
                payload_index, payload_byte, output ready);
endinterface

interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/rfd_in_stage.sv -----
module rfd_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  rfd_in_if.sink         in_if,
  input  logic           pop,
  output logic           item_valid,
  output rfd_pkg::item_t item
);
  import rfd_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_if.ready = !valid_r || pop;
  assign take = in_if.valid && in_if.ready;
  assign valid_nxt = take ? 1'b1 : (pop ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_t'({in_if.opcode, in_if.rx_byte});
    end
  end

  assign item_valid = valid_r;
  assign item = item_r;

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r) else $error("Accepted word was not held.");
  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid_r) else $error("Word consumed from an empty input register.");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!valid_r && !in_if.ready) |-> 1'b0) else $error("Empty input register refused a word.");

endmodule

// ----- rtl/rfd_core.sv -----
module rfd_core (
  input  logic              clk,
  input  logic              rst_n,
  rfd_cfg_if.sink           cfg_if,
  input  logic              item_valid,
  input  rfd_pkg::item_t    item,
  input  rfd_pkg::out_ctl_t out_ctl,
  output logic              pop,
  output logic              res_valid,
  output rfd_pkg::res_t     res
);
  import rfd_pkg::*;

  logic [15:0] timeout_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [7:0]  held_command_r, held_command_nxt;
  logic [15:0] held_length_r, held_length_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  b;

  assign cfg_if.ready = 1'b1;
  assign pop = item_valid && out_ctl.room;
  assign b = item.rx_byte;

  always_comb begin
    phase_nxt        = phase_r;
    held_type_nxt    = held_type_r;
    held_command_nxt = held_command_r;
    held_length_nxt  = held_length_r;
    bytes_nxt        = bytes_r;
    sum_nxt          = sum_r;
    elapsed_nxt      = elapsed_r;
    res_valid        = 1'b0;
    res.event_res      = EV_PAYLOAD;
    res.frame_type     = held_type_r;
    res.frame_command  = held_command_r;
    res.payload_length = held_length_r;
    res.payload_index  = bytes_r;
    res.payload_byte   = 8'h00;
    if (pop) begin
      if (item.opcode == OP_TICK) begin
        if (phase_r != PH_HUNT) begin
          if (elapsed_r != TICKS_MAX) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
          if (elapsed_nxt > timeout_r) begin
            phase_nxt     = PH_HUNT;
            res_valid     = 1'b1;
            res.event_res = EV_TIMEOUT;
          end
        end
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (b == HEADER_BYTE) begin
              held_type_nxt    = 8'h00;
              held_command_nxt = 8'h00;
              held_length_nxt  = 16'h0000;
              bytes_nxt        = 16'h0000;
              sum_nxt          = 8'h00;
              elapsed_nxt      = 16'h0000;
              phase_nxt        = PH_TYPE;
            end
          end
          PH_TYPE: begin
            held_type_nxt = b;
            sum_nxt       = sum_r + b;
            phase_nxt     = PH_CMD;
          end
          PH_CMD: begin
            held_command_nxt = b;
            sum_nxt          = sum_r + b;
            phase_nxt        = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            held_length_nxt = {b, 8'h00};
            sum_nxt         = sum_r + b;
            phase_nxt       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            held_length_nxt = {held_length_r[15:8], b};
            sum_nxt         = sum_r + b;
            bytes_nxt       = 16'h0000;
            phase_nxt       = ({held_length_r[15:8], b} == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.event_res    = EV_PAYLOAD;
            res.payload_byte = b;
            sum_nxt          = sum_r + b;
            bytes_nxt        = bytes_r + 16'd1;
            if (bytes_nxt == held_length_r) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_nxt     = PH_HUNT;
            res_valid     = 1'b1;
            res.event_res = (b == sum_r) ? EV_GOOD : EV_BAD;
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r      <= TIMEOUT_RESET;
      phase_r        <= PH_HUNT;
      held_type_r    <= 8'h00;
      held_command_r <= 8'h00;
      held_length_r  <= 16'h0000;
      bytes_r        <= 16'h0000;
      sum_r          <= 8'h00;
      elapsed_r      <= 16'h0000;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        timeout_r <= cfg_if.data;
      end
      phase_r        <= phase_nxt;
      held_type_r    <= held_type_nxt;
      held_command_r <= held_command_nxt;
      held_length_r  <= held_length_nxt;
      bytes_r        <= bytes_nxt;
      sum_r          <= sum_nxt;
      elapsed_r      <= elapsed_nxt;
    end
  end

  a_hunt_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && item.opcode == OP_TICK && phase_r == PH_HUNT) |-> !res_valid)
    else $error("Tick while hunting produced a word.");
  a_tick_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && item.opcode == OP_TICK && elapsed_r == TICKS_MAX) |=> elapsed_r == TICKS_MAX)
    else $error("Elapsed tick count wrapped.");
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.event_res == EV_PAYLOAD) |-> res.payload_index < held_length_r)
    else $error("Payload index beyond declared length.");
  a_result_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.event_res != EV_PAYLOAD) |=> phase_r == PH_HUNT)
    else $error("Frame end did not return to hunting.");

endmodule

// ----- rtl/rfd_out_stage.sv -----
module rfd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rfd_pkg::res_t     res,
  output rfd_pkg::out_ctl_t out_ctl,
  rfd_out_if.source         out_if
);
  import rfd_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;
  logic room;

  assign room = !valid_r || out_if.ready;
  assign valid_nxt = push ? 1'b1 : (out_if.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_ctl.room = room;

  assign out_if.valid          = valid_r;
  assign out_if.event_res      = res_r.event_res;
  assign out_if.frame_type     = res_r.frame_type;
  assign out_if.frame_command  = res_r.frame_command;
  assign out_if.payload_length = res_r.payload_length;
  assign out_if.payload_index  = res_r.payload_index;
  assign out_if.payload_byte   = res_r.payload_byte;

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> valid_r) else $error("Result word was not presented.");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room) else $error("Result word overwritten before it was taken.");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_if.ready && !push) |=> !valid_r)
    else $error("Taken result word stayed valid.");

endmodule

// ----- rtl/reader_frame_receive_deframer_top.sv -----
// Path: each accepted word is held in the input register; a word that yields
// an event passes through the frame state logic into the result register,
// which holds it until the receiver takes it. Throughput: one word per cycle
// while the result register has room; an input register and a result register sit on
// either side of the frame state update. Reset (rst_n low, synchronous) returns to
// header hunting, empties both registers and sets the timeout to 20 ticks.
module reader_frame_receive_deframer_top (
  input  logic      clk,
  input  logic      rst_n,
  rfd_in_if.sink    in_if,
  rfd_cfg_if.sink   cfg_if,
  rfd_out_if.source out_if
);
  import rfd_pkg::*;

  logic     item_valid;
  item_t    item;
  logic     pop;
  logic     res_valid;
  res_t     res;
  out_ctl_t out_ctl;

  rfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  rfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_if     (cfg_if),
    .item_valid (item_valid),
    .item       (item),
    .out_ctl    (out_ctl),
    .pop        (pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  rfd_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_valid),
    .res     (res),
    .out_ctl (out_ctl),
    .out_if  (out_if)
  );

endmodule

// ----- dv/rfd_event_checker.sv -----
module rfd_event_checker (
  input  logic clk,
  input  logic rst_n,
  rfd_in_if    in_mon,
  rfd_cfg_if   cfg_mon,
  rfd_out_if   out_mon,
  output int   n_expected,
  output int   n_errors
);
  import rfd_pkg::*;

  logic [15:0] timeout_ticks;
  phase_t      phase;
  logic [7:0]  held_type;
  logic [7:0]  held_cmd;
  logic [15:0] held_len;
  logic [15:0] n_payload;
  logic [7:0]  sum;
  logic [15:0] ticks;
  res_t        expected_events[$];
  int          errs = 0;

  // Advances the frame state by one word and reports whether it yields an event.
  function automatic bit deframe_word(input op_t op, input logic [7:0] b, output res_t r);
    r = '0;
    r.frame_type     = held_type;
    r.frame_command  = held_cmd;
    r.payload_length = held_len;
    r.payload_index  = n_payload;
    if (op == OP_TICK) begin
      if (phase == PH_HUNT) return 1'b0;
      if (ticks != TICKS_MAX) ticks = ticks + 16'd1;
      if (ticks > timeout_ticks) begin
        phase = PH_HUNT;
        r.event_res = EV_TIMEOUT;
        return 1'b1;
      end
      return 1'b0;
    end
    case (phase)
      PH_HUNT: begin
        if (b == HEADER_BYTE) begin
          held_type = '0;
          held_cmd  = '0;
          held_len  = '0;
          n_payload = '0;
          sum       = '0;
          ticks     = '0;
          phase     = PH_TYPE;
        end
        return 1'b0;
      end
      PH_TYPE: begin
        held_type = b;
        sum       = sum + b;
        phase     = PH_CMD;
        return 1'b0;
      end
      PH_CMD: begin
        held_cmd = b;
        sum      = sum + b;
        phase    = PH_LEN_HI;
        return 1'b0;
      end
      PH_LEN_HI: begin
        held_len = {b, 8'h00};
        sum      = sum + b;
        phase    = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        held_len  = {held_len[15:8], b};
        sum       = sum + b;
        n_payload = '0;
        phase     = (held_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        r.event_res    = EV_PAYLOAD;
        r.payload_byte = b;
        sum            = sum + b;
        n_payload      = n_payload + 16'd1;
        if (n_payload == held_len) phase = PH_CHECK;
        return 1'b1;
      end
      PH_CHECK: begin
        phase       = PH_HUNT;
        r.event_res = (b == sum) ? EV_GOOD : EV_BAD;
        return 1'b1;
      end
      default: begin
        phase = PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string event_str(input res_t r);
    return $sformatf("ev=%0d type=%h cmd=%h len=%h idx=%h byte=%h", r.event_res,
                     r.frame_type, r.frame_command, r.payload_length, r.payload_index,
                     r.payload_byte);
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      timeout_ticks = TIMEOUT_RESET;
      phase         = PH_HUNT;
      held_type     = '0;
      held_cmd      = '0;
      held_len      = '0;
      n_payload     = '0;
      sum           = '0;
      ticks         = '0;
      expected_events.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.event_res      = ev_t'(out_mon.event_res);
        got.frame_type     = out_mon.frame_type;
        got.frame_command  = out_mon.frame_command;
        got.payload_length = out_mon.payload_length;
        got.payload_index  = out_mon.payload_index;
        got.payload_byte   = out_mon.payload_byte;
        if (expected_events.size() == 0) begin
          errs++;
          if (errs <= 10) $display("Unexpected word: %s", event_str(got));
        end else begin
          want = expected_events.pop_front();
          if (got.event_res !== want.event_res || got.frame_type !== want.frame_type ||
              got.frame_command !== want.frame_command ||
              got.payload_length !== want.payload_length ||
              got.payload_index !== want.payload_index ||
              got.payload_byte !== want.payload_byte) begin
            errs++;
            if (errs <= 10) begin
              $display("Mismatch: expected %s", event_str(want));
              $display("          actual   %s", event_str(got));
            end
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) timeout_ticks = cfg_mon.data;
      if (in_mon.valid && in_mon.ready) begin
        if (deframe_word(op_t'(in_mon.opcode), in_mon.rx_byte, want))
          expected_events.insert(expected_events.size(), want);
      end
    end
    n_expected <= expected_events.size();
    n_errors   <= errs;
  end

endmodule

// ----- dv/reader_frame_receive_deframer_top_tb.sv -----
module reader_frame_receive_deframer_top_tb;
  import rfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  int          n_expected;
  int          n_errors;
  int          n_counted;
  int          cycle_cnt;
  logic [15:0] cur_timeout;
  bit          stall_hold;
  bit          no_gaps;
  event        hold_ev;

  rfd_in_if  in_ch ();
  rfd_cfg_if cfg_ch ();
  rfd_out_if out_ch ();

  reader_frame_receive_deframer_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .cfg_if (cfg_ch),
    .out_if (out_ch)
  );

  rfd_event_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .cfg_mon    (cfg_ch),
    .out_mon    (out_ch),
    .n_expected (n_expected),
    .n_errors   (n_errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_word(input op_t op, input logic [7:0] b, input bit counted);
    int r;
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (counted) n_counted++;
    r = $urandom_range(0, 99);
    if (r < 50) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (!no_gaps && gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a frame with n_pay payload words, capped at len; the checksum follows only when the
  // payload is complete. Ticks may be mixed in after the header.
  task automatic send_frame(input logic [7:0] typ, input logic [7:0] cmd,
                            input logic [15:0] len, input int n_pay, input bit bad,
                            input int tick_pct);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    frame_bytes = {HEADER_BYTE, typ, cmd, len[15:8], len[7:0]};
    sum = typ + cmd + len[15:8] + len[7:0];
    for (i = 0; i < n_pay && i < int'(len); i++) begin
      b = 8'($urandom);
      sum = sum + b;
      frame_bytes = {frame_bytes, b};
    end
    if (n_pay >= int'(len)) begin
      b = bad ? sum ^ 8'($urandom_range(1, 255)) : sum;
      frame_bytes = {frame_bytes, b};
    end
    foreach (frame_bytes[k]) begin
      if (k > 0 && $urandom_range(0, 99) < tick_pct) send_word(OP_TICK, 8'($urandom), 1'b1);
      send_word(OP_BYTE, frame_bytes[k], 1'b1);
    end
  endtask

  task automatic write_timeout(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_expected != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_timeout = v;
  endtask

  initial begin
    int  run;
    int  r;
    bit  lvl;
    out_ch.ready <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        lvl = 1'b1;
        run = $urandom_range(1, 20);
      end else if (r < 95) begin
        lvl = 1'b0;
        run = $urandom_range(1, 3);
      end else begin
        lvl = 1'b0;
        run = $urandom_range(10, 40);
      end
      repeat (run) begin
        @(posedge clk);
        out_ch.ready <= lvl && !stall_hold;
      end
    end
  end

  // The receiver holds off long enough for the block to back up to its input.
  initial begin
    int held;
    stall_hold <= 1'b0;
    forever begin
      @(hold_ev);
      @(posedge clk);
      stall_hold <= 1'b1;
      held = 0;
      while (held < 300) begin
        @(posedge clk);
        held++;
      end
      stall_hold <= 1'b0;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL reader_frame_receive_deframer_top");
    $finish;
  end

  initial begin
    logic [15:0] timeout_plan[6];
    int          ph;
    int          r;
    int          len;
    int          goal;
    int          k;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_BYTE;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= 16'h0000;
    no_gaps     = 1'b0;
    n_counted   = 0;
    cur_timeout = TIMEOUT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_TICK, 8'h00, 1'b0);
    send_word(OP_BYTE, 8'h00, 1'b0);
    send_word(OP_BYTE, 8'hFF, 1'b0);
    send_word(OP_BYTE, HEADER_BYTE ^ 8'h01, 1'b0);
    send_frame(8'hFF, 8'h00, 16'h0002, 2, 1'b0, 0);
    send_frame(8'h00, 8'hFF, 16'h0000, 0, 1'b1, 0);
    write_timeout(16'd1);
    send_frame(8'h5A, 8'hA5, 16'hFFFF, 1, 1'b0, 0);
    send_word(OP_TICK, 8'hFF, 1'b1);
    send_word(OP_TICK, 8'h00, 1'b1);

    timeout_plan = '{TIMEOUT_RESET, 16'd0, TICKS_MAX, 16'd3, 16'($urandom_range(4, 40)),
                     16'd1};
    for (ph = 0; ph < 6; ph++) begin
      write_timeout(timeout_plan[ph]);
      if (ph == 0 || ph == 3) begin
        -> hold_ev;
        send_frame(8'($urandom), 8'($urandom), 16'd24, 24, 1'b0, 0);
      end
      goal = n_counted + 100;
      while (n_counted < goal) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          send_frame(8'($urandom), 8'($urandom), 16'(len), len, $urandom_range(0, 3) == 0,
                     ($urandom_range(0, 3) == 0) ? 15 : 0);
        end else if (r < 82) begin
          if (cur_timeout < 16'd100) begin
            len = $urandom_range(1, 65535);
            send_frame(8'($urandom), 8'($urandom), 16'(len), $urandom_range(0, 6), 1'b0, 0);
            repeat (int'(cur_timeout) + 1) send_word(OP_TICK, 8'($urandom), 1'b1);
          end else begin
            len = $urandom_range(2, 8);
            send_frame(8'($urandom), 8'($urandom), 16'(len), $urandom_range(0, len - 1),
                       1'b0, 0);
          end
        end else if (r < 94) begin
          repeat ($urandom_range(1, 4))
            send_word($urandom_range(0, 1) ? OP_TICK : OP_BYTE, 8'($urandom), 1'b0);
        end else begin
          repeat ($urandom_range(1, 6)) send_word(OP_TICK, 8'($urandom), 1'b1);
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    k = 0;
    while (n_expected != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (10) @(posedge clk);
    if (n_errors == 0 && n_expected == 0) begin
      $display("PASS reader_frame_receive_deframer_top");
    end else begin
      $display("FAIL reader_frame_receive_deframer_top");
    end
    $finish;
  end

endmodule
